[src/ldpc_hd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldpc_hd_pkg
// Shared types, codes and defaults of the hard-decision LDPC decoder.
// ----------------------------------------------------------------------------
package ldpc_hd_pkg;

  localparam int NUM_VARS_DEF   = 64;
  localparam int NUM_CHECKS_DEF = 32;

  localparam logic [3:0] LIMIT_RESET  = 4'd10;
  localparam logic [6:0] VCOUNT_RESET = 7'd64;
  localparam logic [5:0] CCOUNT_RESET = 6'd32;

  localparam logic [1:0] CMD_LOAD_ROW  = 2'd0;
  localparam logic [1:0] CMD_LOAD_WORD = 2'd1;
  localparam logic [1:0] CMD_DECODE    = 2'd2;

  localparam logic [1:0] REG_LIMIT  = 2'd0;
  localparam logic [1:0] REG_VCOUNT = 2'd1;
  localparam logic [1:0] REG_CCOUNT = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  check_row;
    logic [63:0] row_bits;
    logic [63:0] received_bits;
  } in_word_t;

  typedef struct packed {
    logic [5:0] bit_index;
    logic       decoded_bit;
    logic       converged;
    logic [3:0] iterations_used;
    logic       last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS_RD,
    ST_PASS_WR,
    ST_PASS_END,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_row;
    logic load_word;
    logic start;
    logic pass_init;
    logic rd_row;
    logic wr_row;
    logic pass_end;
    logic decide;
    logic emit_next;
  } ctrl_t;

  typedef struct packed {
    logic lim_zero;
    logic nc_zero;
    logic row_last;
    logic lim_reached;
    logic conv_hit;
    logic emit_last;
  } status_t;

endpackage
`default_nettype wire

[src/ldpc_hd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldpc_hd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ldpc_hd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wen,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             ren,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/ldpc_hd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldpc_hd_ctrl
// Decode sequencer: row passes, decision steps and result emission.
// ----------------------------------------------------------------------------
module ldpc_hd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           cmd,
  input  wire logic                 out_stall,
  input  wire ldpc_hd_pkg::status_t status,
  output logic                      in_stall,
  output logic                      out_valid,
  output ldpc_hd_pkg::ctrl_t        ctrl
);

  ldpc_hd_pkg::state_t state, state_next;
  logic in_acc, out_acc;

  assign in_acc  = in_valid && (state == ldpc_hd_pkg::ST_IDLE);
  assign out_acc = (state == ldpc_hd_pkg::ST_EMIT) && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldpc_hd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ldpc_hd_pkg::ST_IDLE: begin
        if (in_acc && cmd == ldpc_hd_pkg::CMD_DECODE) begin
          if (status.lim_zero) state_next = ldpc_hd_pkg::ST_EMIT;
          else if (status.nc_zero) state_next = ldpc_hd_pkg::ST_PASS_END;
          else state_next = ldpc_hd_pkg::ST_PASS_RD;
        end
      end
      ldpc_hd_pkg::ST_PASS_RD: state_next = ldpc_hd_pkg::ST_PASS_WR;
      ldpc_hd_pkg::ST_PASS_WR: begin
        state_next = status.row_last ? ldpc_hd_pkg::ST_PASS_END : ldpc_hd_pkg::ST_PASS_RD;
      end
      ldpc_hd_pkg::ST_PASS_END: begin
        state_next = status.lim_reached ? ldpc_hd_pkg::ST_EMIT : ldpc_hd_pkg::ST_DECIDE;
      end
      ldpc_hd_pkg::ST_DECIDE: begin
        if (status.conv_hit) state_next = ldpc_hd_pkg::ST_EMIT;
        else if (status.nc_zero) state_next = ldpc_hd_pkg::ST_PASS_END;
        else state_next = ldpc_hd_pkg::ST_PASS_RD;
      end
      ldpc_hd_pkg::ST_EMIT: begin
        if (out_acc && status.emit_last) state_next = ldpc_hd_pkg::ST_IDLE;
      end
      default: state_next = ldpc_hd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    in_stall  = (state != ldpc_hd_pkg::ST_IDLE);
    out_valid = (state == ldpc_hd_pkg::ST_EMIT);
    case (state)
      ldpc_hd_pkg::ST_IDLE: begin
        ctrl.load_row  = in_acc && (cmd == ldpc_hd_pkg::CMD_LOAD_ROW);
        ctrl.load_word = in_acc && (cmd == ldpc_hd_pkg::CMD_LOAD_WORD);
        ctrl.start     = in_acc && (cmd == ldpc_hd_pkg::CMD_DECODE);
        ctrl.pass_init = ctrl.start;
      end
      ldpc_hd_pkg::ST_PASS_RD:  ctrl.rd_row   = 1'b1;
      ldpc_hd_pkg::ST_PASS_WR:  ctrl.wr_row   = 1'b1;
      ldpc_hd_pkg::ST_PASS_END: ctrl.pass_end = 1'b1;
      ldpc_hd_pkg::ST_DECIDE: begin
        ctrl.decide    = 1'b1;
        ctrl.pass_init = !status.conv_hit;
      end
      ldpc_hd_pkg::ST_EMIT: ctrl.emit_next = out_acc;
      default: ctrl = '0;
    endcase
  end

endmodule
`default_nettype wire

[src/ldpc_hd_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldpc_hd_dp
// Datapath: config registers, matrix and message RAMs, per-bit vote counters.
// ----------------------------------------------------------------------------
module ldpc_hd_dp #(
  parameter int NUM_VARS   = ldpc_hd_pkg::NUM_VARS_DEF,
  parameter int NUM_CHECKS = ldpc_hd_pkg::NUM_CHECKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [6:0]            cfg_data,
  input  wire ldpc_hd_pkg::in_word_t in_word,
  input  wire ldpc_hd_pkg::ctrl_t    ctrl,
  output ldpc_hd_pkg::status_t       status,
  output ldpc_hd_pkg::out_word_t     out_word
);

  localparam int AW  = (NUM_CHECKS > 1) ? $clog2(NUM_CHECKS) : 1;
  localparam int CW  = $clog2(NUM_CHECKS + 1);
  localparam int SW  = CW + 2;
  localparam int VW  = $clog2(NUM_VARS);
  localparam int VCW = $clog2(NUM_VARS + 1);

  logic [3:0] lim_cfg;
  logic [6:0] vcount_cfg;
  logic [5:0] ccount_cfg;

  logic [3:0]          lim, itr;
  logic [VCW-1:0]      nv;
  logic [CW-1:0]       nc, row;
  logic [NUM_VARS-1:0] vmask, rword, r, dec, prev;
  logic                have_prev, mode, conv;
  logic [VW-1:0]       emit_idx;
  logic [CW-1:0]       ones_cur [NUM_VARS];
  logic [CW-1:0]       deg_cur  [NUM_VARS];
  logic [CW-1:0]       ones_acc [NUM_VARS];
  logic [CW-1:0]       deg_acc  [NUM_VARS];

  logic [NUM_VARS-1:0] h_rd, c2v_rd, row_m, v2c, c2v_new, nd;
  logic [VCW-1:0]      nv_sel;
  logic [CW-1:0]       nc_sel;
  logic                par;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lim_cfg    <= ldpc_hd_pkg::LIMIT_RESET;
      vcount_cfg <= ldpc_hd_pkg::VCOUNT_RESET;
      ccount_cfg <= ldpc_hd_pkg::CCOUNT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        ldpc_hd_pkg::REG_LIMIT:  lim_cfg    <= cfg_data[3:0];
        ldpc_hd_pkg::REG_VCOUNT: vcount_cfg <= cfg_data;
        ldpc_hd_pkg::REG_CCOUNT: ccount_cfg <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // clamp counts to the built size
  always_comb begin
    if ({25'd0, vcount_cfg} > NUM_VARS) nv_sel = VCW'(NUM_VARS);
    else if (vcount_cfg == 7'd0) nv_sel = VCW'(1);
    else nv_sel = VCW'(vcount_cfg);
    if ({26'd0, ccount_cfg} > NUM_CHECKS) nc_sel = CW'(NUM_CHECKS);
    else nc_sel = CW'(ccount_cfg);
  end

  ldpc_hd_ram #(.WIDTH(NUM_VARS), .DEPTH(NUM_CHECKS)) u_h_ram (
    .clk   (clk),
    .wen   (ctrl.load_row && ({27'd0, in_word.check_row} < NUM_CHECKS)),
    .waddr (AW'(in_word.check_row)),
    .wdata (in_word.row_bits[NUM_VARS-1:0]),
    .ren   (ctrl.rd_row),
    .raddr (row[AW-1:0]),
    .rdata (h_rd)
  );

  ldpc_hd_ram #(.WIDTH(NUM_VARS), .DEPTH(NUM_CHECKS)) u_c2v_ram (
    .clk   (clk),
    .wen   (ctrl.wr_row),
    .waddr (row[AW-1:0]),
    .wdata (c2v_new),
    .ren   (ctrl.rd_row),
    .raddr (row[AW-1:0]),
    .rdata (c2v_rd)
  );

  // per-bit variable votes, check parity and decision
  always_comb begin
    logic [SW-1:0] a2, d2, dn;
    logic          vmsg;
    for (int j = 0; j < NUM_VARS; j++) begin
      row_m[j] = h_rd[j] & vmask[j];
      a2 = (SW'(ones_cur[j]) - SW'(c2v_rd[j]) + SW'(r[j])) << 1;
      if (a2 > SW'(deg_cur[j])) vmsg = 1'b1;
      else if (a2 < SW'(deg_cur[j])) vmsg = 1'b0;
      else vmsg = r[j];
      v2c[j] = (mode ? vmsg : r[j]) & row_m[j];
      d2 = (SW'(ones_cur[j]) + SW'(r[j])) << 1;
      dn = SW'(deg_cur[j]) + SW'(1);
      if (d2 > dn) nd[j] = vmask[j];
      else if (d2 < dn) nd[j] = 1'b0;
      else nd[j] = r[j];
    end
    par     = ^v2c;
    c2v_new = (par ? ~v2c : v2c) & row_m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rword <= '0;
      prev  <= '0;
    end else begin
      if (ctrl.load_word) rword <= in_word.received_bits[NUM_VARS-1:0];
      if (ctrl.decide && !(have_prev && nd == prev)) prev <= nd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      lim       <= lim_cfg;
      nv        <= nv_sel;
      nc        <= nc_sel;
      itr       <= '0;
      mode      <= 1'b0;
      have_prev <= 1'b0;
      conv      <= 1'b0;
      emit_idx  <= '0;
      for (int j = 0; j < NUM_VARS; j++) begin
        vmask[j] <= (VCW'(j) < nv_sel);
        r[j]     <= rword[j] & (VCW'(j) < nv_sel);
        dec[j]   <= rword[j] & (VCW'(j) < nv_sel);
      end
    end
    if (ctrl.pass_init) begin
      row <= '0;
      for (int j = 0; j < NUM_VARS; j++) begin
        ones_acc[j] <= '0;
        deg_acc[j]  <= '0;
      end
    end
    if (ctrl.wr_row) begin
      row <= row + CW'(1);
      for (int j = 0; j < NUM_VARS; j++) begin
        ones_acc[j] <= ones_acc[j] + CW'(c2v_new[j]);
        deg_acc[j]  <= deg_acc[j] + CW'(row_m[j]);
      end
    end
    if (ctrl.pass_end) begin
      itr  <= itr + 4'd1;
      mode <= 1'b1;
      for (int j = 0; j < NUM_VARS; j++) begin
        ones_cur[j] <= ones_acc[j];
        deg_cur[j]  <= deg_acc[j];
      end
    end
    if (ctrl.decide) begin
      dec       <= nd;
      have_prev <= 1'b1;
      if (have_prev && nd == prev) conv <= 1'b1;
    end
    if (ctrl.emit_next) emit_idx <= emit_idx + VW'(1);
  end

  always_comb begin
    status.lim_zero    = (lim_cfg == 4'd0);
    status.nc_zero     = ctrl.start ? (nc_sel == '0) : (nc == '0);
    status.row_last    = (row == nc - CW'(1));
    status.lim_reached = (itr + 4'd1 == lim);
    status.conv_hit    = have_prev && (nd == prev);
    status.emit_last   = ({1'b0, emit_idx} == VCW'(nv - VCW'(1)));
  end

  always_comb begin
    out_word.bit_index       = 6'(emit_idx);
    out_word.decoded_bit     = dec[emit_idx];
    out_word.converged       = conv;
    out_word.iterations_used = itr;
    out_word.last            = status.emit_last;
  end

endmodule
`default_nettype wire

[src/ldpc_hard_decision_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldpc_hard_decision_decoder
// Gallager-B style hard-decision LDPC decoder with command-loaded matrix.
// ----------------------------------------------------------------------------
// A decode passes messages row by row until the limit L stops it or the
//   decisions repeat, then emits one word per cycle unless stalled, V in all.
// The matrix / message RAM port, read once per row per iteration, sets the pace.
// Reset (rst, synchronous) clears control state and config to limit 10,
// 64 bits, 32 checks; matrix rows are undefined until written.
// ----------------------------------------------------------------------------
module ldpc_hard_decision_decoder #(
  parameter int NUM_VARS   = ldpc_hd_pkg::NUM_VARS_DEF,
  parameter int NUM_CHECKS = ldpc_hd_pkg::NUM_CHECKS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wen,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [6:0]             cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire ldpc_hd_pkg::in_word_t  in_word,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output ldpc_hd_pkg::out_word_t      out_word
);

  ldpc_hd_pkg::ctrl_t   ctrl;
  ldpc_hd_pkg::status_t status;

  // sequencer: one word in while idle, busy until the last result word leaves
  ldpc_hd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (in_word.cmd),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  // datapath: RAMs, per-bit counters, decision and output registers
  ldpc_hd_dp #(
    .NUM_VARS   (NUM_VARS),
    .NUM_CHECKS (NUM_CHECKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .ctrl      (ctrl),
    .status    (status),
    .out_word  (out_word)
  );

  // no new word taken while results are going out
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken during emission");

  // last result word ends the burst
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_word.last) |=> !out_valid)
    else $error("results continue after last");

  // decode start makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_word.cmd == ldpc_hd_pkg::CMD_DECODE) |=> in_stall)
    else $error("decode did not start");

endmodule
`default_nettype wire
